[src/ledseq_pkg.sv]
// Shared types and constants for the LED animation sequencer.
// Used by ledseq_cfg_regs, ledseq_engine and led_animation_sequencer; no dependencies.
`default_nettype none

package ledseq_pkg;

    localparam int unsigned TIME_W     = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned MODE_W     = 3;

    // Input commands.
    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_SET  = 2'd1,
        CMD_NEXT = 2'd2,
        CMD_PREV = 2'd3
    } cmd_t;

    // Animation mode codes; codes above MODE_LONG are not modes.
    localparam logic [MODE_W-1:0] MODE_OFF   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ON    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_BLINK = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SHORT = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LONG  = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_HALF  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_BURST = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_GAP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_ON    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_OFF   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_ON     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_OFF    = 3'd6;

    // Reset values of the timing registers, in milliseconds.
    localparam logic [TIME_W-1:0] RST_BLINK_HALF  = 16'd50;
    localparam logic [TIME_W-1:0] RST_BLINK_BURST = 16'd600;
    localparam logic [TIME_W-1:0] RST_BLINK_GAP   = 16'd300;
    localparam logic [TIME_W-1:0] RST_SHORT_ON    = 16'd300;
    localparam logic [TIME_W-1:0] RST_SHORT_OFF   = 16'd700;
    localparam logic [TIME_W-1:0] RST_LONG_ON     = 16'd500;
    localparam logic [TIME_W-1:0] RST_LONG_OFF    = 16'd500;

    localparam logic [TIME_W-1:0] TIME_MAX = 16'hFFFF;

    typedef struct packed {
        logic [TIME_W-1:0] blink_half_period;
        logic [TIME_W-1:0] blink_burst_len;
        logic [TIME_W-1:0] blink_gap_len;
        logic [TIME_W-1:0] short_on_time;
        logic [TIME_W-1:0] short_off_time;
        logic [TIME_W-1:0] long_on_time;
        logic [TIME_W-1:0] long_off_time;
    } timing_cfg_t;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [MODE_W-1:0] mode_value;
    } in_item_t;

    typedef struct packed {
        logic              led_level;
        logic [MODE_W-1:0] active_mode;
    } out_item_t;

endpackage

`default_nettype wire

[src/ledseq_cfg_regs.sv]
// Timing configuration register file of the LED animation sequencer.
// Depends on ledseq_pkg for the register indexes, reset values and timing_cfg_t.
`default_nettype none

module ledseq_cfg_regs (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_wr_en,
    input  wire logic [ledseq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ledseq_pkg::TIME_W-1:0]      cfg_wdata,
    output ledseq_pkg::timing_cfg_t                 timing
);

    ledseq_pkg::timing_cfg_t cfg_reg;
    ledseq_pkg::timing_cfg_t cfg_next;

    // Writes to an index past the last register are dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                ledseq_pkg::REG_BLINK_HALF:  cfg_next.blink_half_period = cfg_wdata;
                ledseq_pkg::REG_BLINK_BURST: cfg_next.blink_burst_len   = cfg_wdata;
                ledseq_pkg::REG_BLINK_GAP:   cfg_next.blink_gap_len     = cfg_wdata;
                ledseq_pkg::REG_SHORT_ON:    cfg_next.short_on_time     = cfg_wdata;
                ledseq_pkg::REG_SHORT_OFF:   cfg_next.short_off_time    = cfg_wdata;
                ledseq_pkg::REG_LONG_ON:     cfg_next.long_on_time      = cfg_wdata;
                ledseq_pkg::REG_LONG_OFF:    cfg_next.long_off_time     = cfg_wdata;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.blink_half_period <= ledseq_pkg::RST_BLINK_HALF;
            cfg_reg.blink_burst_len   <= ledseq_pkg::RST_BLINK_BURST;
            cfg_reg.blink_gap_len     <= ledseq_pkg::RST_BLINK_GAP;
            cfg_reg.short_on_time     <= ledseq_pkg::RST_SHORT_ON;
            cfg_reg.short_off_time    <= ledseq_pkg::RST_SHORT_OFF;
            cfg_reg.long_on_time      <= ledseq_pkg::RST_LONG_ON;
            cfg_reg.long_off_time     <= ledseq_pkg::RST_LONG_OFF;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign timing = cfg_reg;

endmodule

`default_nettype wire

[src/ledseq_engine.sv]
// Animation state and per-item update logic of the LED animation sequencer.
// Depends on ledseq_pkg for the command, mode and timing definitions.
`default_nettype none

module ledseq_engine (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     step,
    input  ledseq_pkg::in_item_t          item,
    input  ledseq_pkg::timing_cfg_t       timing,
    output ledseq_pkg::out_item_t         result
);

    logic [ledseq_pkg::MODE_W-1:0] mode_reg,  mode_next;
    logic                          led_reg,   led_next;
    logic [ledseq_pkg::TIME_W-1:0] phase_reg, phase_next;
    logic [ledseq_pkg::TIME_W-1:0] burst_reg, burst_next;
    logic                          gap_reg,   gap_next;

    logic [ledseq_pkg::TIME_W-1:0] phase_inc;
    logic [ledseq_pkg::TIME_W-1:0] burst_inc;
    logic [ledseq_pkg::TIME_W-1:0] on_time;
    logic [ledseq_pkg::TIME_W-1:0] off_time;
    logic                          enter;
    logic [ledseq_pkg::MODE_W-1:0] enter_mode;

    // Saturating increments of both counters.
    assign phase_inc = (phase_reg == ledseq_pkg::TIME_MAX) ? phase_reg
                                                           : phase_reg + 16'd1;
    assign burst_inc = (burst_reg == ledseq_pkg::TIME_MAX) ? burst_reg
                                                           : burst_reg + 16'd1;

    assign on_time  = (mode_reg == ledseq_pkg::MODE_SHORT) ? timing.short_on_time
                                                           : timing.long_on_time;
    assign off_time = (mode_reg == ledseq_pkg::MODE_SHORT) ? timing.short_off_time
                                                           : timing.long_off_time;

    // Mode change decode.
    always_comb
    begin
        enter      = 1'b0;
        enter_mode = mode_reg;
        unique case (ledseq_pkg::cmd_t'(item.cmd))
            ledseq_pkg::CMD_TICK:
            begin
                enter = 1'b0;
            end
            ledseq_pkg::CMD_SET:
            begin
                enter      = (item.mode_value <= ledseq_pkg::MODE_LONG);
                enter_mode = item.mode_value;
            end
            ledseq_pkg::CMD_NEXT:
            begin
                enter      = 1'b1;
                enter_mode = (mode_reg == ledseq_pkg::MODE_LONG) ? ledseq_pkg::MODE_OFF
                                                                 : mode_reg + 3'd1;
            end
            ledseq_pkg::CMD_PREV:
            begin
                enter      = 1'b1;
                enter_mode = (mode_reg == ledseq_pkg::MODE_OFF) ? ledseq_pkg::MODE_LONG
                                                                : mode_reg - 3'd1;
            end
        endcase
    end

    // Next state for one item.
    always_comb
    begin
        mode_next  = mode_reg;
        led_next   = led_reg;
        phase_next = phase_reg;
        burst_next = burst_reg;
        gap_next   = gap_reg;
        if (enter)
        begin
            mode_next  = enter_mode;
            led_next   = (enter_mode != ledseq_pkg::MODE_OFF);
            phase_next = '0;
            burst_next = '0;
            gap_next   = 1'b0;
        end
        else if (ledseq_pkg::cmd_t'(item.cmd) == ledseq_pkg::CMD_TICK)
        begin
            if (mode_reg == ledseq_pkg::MODE_BLINK)
            begin
                if (gap_reg)
                begin
                    if (phase_inc >= timing.blink_gap_len)
                    begin
                        phase_next = '0;
                        burst_next = '0;
                        gap_next   = 1'b0;
                        led_next   = 1'b1;
                    end
                    else
                    begin
                        phase_next = phase_inc;
                    end
                end
                else if (phase_inc >= timing.blink_half_period)
                begin
                    phase_next = '0;
                    if (burst_inc >= timing.blink_burst_len)
                    begin
                        led_next   = 1'b0;
                        gap_next   = 1'b1;
                        burst_next = '0;
                    end
                    else
                    begin
                        led_next   = ~led_reg;
                        burst_next = burst_inc;
                    end
                end
                else
                begin
                    phase_next = phase_inc;
                    burst_next = burst_inc;
                end
            end
            else if (mode_reg == ledseq_pkg::MODE_SHORT || mode_reg == ledseq_pkg::MODE_LONG)
            begin
                if (led_reg ? (phase_inc >= on_time) : (phase_inc >= off_time))
                begin
                    led_next   = ~led_reg;
                    phase_next = '0;
                end
                else
                begin
                    phase_next = phase_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= ledseq_pkg::MODE_OFF;
            led_reg   <= 1'b0;
            phase_reg <= '0;
            burst_reg <= '0;
            gap_reg   <= 1'b0;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            led_reg   <= led_next;
            phase_reg <= phase_next;
            burst_reg <= burst_next;
            gap_reg   <= gap_next;
        end
    end

    assign result.led_level   = led_next;
    assign result.active_mode = mode_next;

    // The mode register only ever holds a valid mode.
    a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg <= ledseq_pkg::MODE_LONG)
        else $error("mode register holds an invalid mode");

    // The blink gap exists only in blink mode, and the LED is dark in it.
    a_gap_blink: assert property (@(posedge clk) disable iff (!rst_n)
        gap_reg |-> (mode_reg == ledseq_pkg::MODE_BLINK) && !led_reg)
        else $error("blink gap flag set outside a dark blink phase");

    // Off mode never lights the LED.
    a_off_dark: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == ledseq_pkg::MODE_OFF) |-> !led_reg)
        else $error("LED lit in off mode");

endmodule

`default_nettype wire

[src/led_animation_sequencer.sv]
// Top level of the LED animation sequencer: input register, output register and glue.
// Depends on ledseq_pkg, ledseq_cfg_regs and ledseq_engine.
//
// Usage:
//   Input channel (in_valid, in_stall, in_data) carries one command per transfer:
//   a one-millisecond tick, a direct mode set, or a step to the next or previous
//   mode. Output channel (out_valid, out_stall, out_data) returns exactly one result
//   per input transfer, in order: the LED level and the active mode after that item.
//   A transfer happens on a rising clock edge where valid is high and stall is low.
//
//   An item taken is held in the input register, processed by the engine, and its
//   result is loaded into the output register and presented from there. Throughput
//   is one item per cycle while the receiver does not stall, set by the state
//   update between the input register and the output register. The input register
//   frees as the result register loads, so a new item is taken while an earlier
//   result waits to be collected.
//
//   When the receiver stalls, the result stays in the output register, the pending
//   item stays in the input register, and in_stall rises only once both are full.
//
//   Reset (rst_n low, asynchronous) empties both registers, returns the mode to
//   off with the LED dark and loads the default timing values. The timing registers
//   are written through cfg_wr_en / cfg_index / cfg_wdata, by the user only while the
//   block is idle, which it does not enforce; indexes past the last one are ignored.
`default_nettype none

module led_animation_sequencer (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  ledseq_pkg::in_item_t                    in_data,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output ledseq_pkg::out_item_t                   out_data,
    input  wire logic                               cfg_wr_en,
    input  wire logic [ledseq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ledseq_pkg::TIME_W-1:0]      cfg_wdata
);

    logic                    in_valid_reg, in_valid_next;
    ledseq_pkg::in_item_t    in_data_reg;
    logic                    out_valid_reg, out_valid_next;
    ledseq_pkg::out_item_t   out_data_reg;

    ledseq_pkg::timing_cfg_t timing;
    ledseq_pkg::out_item_t   result;

    logic                    advance;
    logic                    accept_in;
    logic                    step;

    // The output register can take a new result when it is empty or being drained.
    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = in_valid_reg && !advance;
    assign accept_in = in_valid && !in_stall;
    assign step      = in_valid_reg && advance;

    assign in_valid_next  = accept_in || (in_valid_reg && !advance);
    assign out_valid_next = step || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            in_data_reg <= in_data;
        end
        if (step)
        begin
            out_data_reg <= result;
        end
    end

    ledseq_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .timing    (timing)
    );

    ledseq_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_data_reg),
        .timing (timing),
        .result (result)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A pending item is kept until the engine consumes it.
    a_hold_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("pending input item dropped");

    // Every processed item produces a result in the next cycle.
    a_step_result: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("processed item produced no result");

    // Input is only held off while the output register is full and stalled.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall && in_valid_reg))
        else $error("input stalled without a full output");

    // Results never report an invalid mode.
    a_out_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.active_mode <= ledseq_pkg::MODE_LONG))
        else $error("result carries an invalid mode");

endmodule

`default_nettype wire
